FILE: rtl/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared constants, types and the cordic arctangent table of the
// windowed-sinc fir coefficient designer.
// ----------------------------------------------------------------------------
package wsf_pkg;

	localparam int MAX_ORDER    = 62;
	localparam int ORDER_W      = 6;
	localparam int CUTOFF_W     = 16;
	localparam int IDX_W        = 6;
	localparam int COEF_W       = 24;
	localparam int STATUS_W     = 2;
	localparam int TAP_W        = 32;
	localparam int SUM_W        = 40;
	localparam int TAP_DEPTH    = MAX_ORDER + 1;
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = 5;
	localparam int DIV_NUM_W    = 53;
	localparam int DIV_DEN_W    = 40;
	localparam int DIV_CNT_W    = 6;
	localparam int PROD_W       = 64;
	localparam int VAL_W        = 56;

	localparam logic signed [CORDIC_W-1:0] CORDIC_K    = 34'sd652032874;
	localparam logic signed [CORDIC_W-1:0] QUARTER     = 34'sd1073741824;
	localparam logic signed [CORDIC_W-1:0] HALF        = 34'sd2147483648;
	localparam logic signed [TAP_W-1:0]    TWO_OVER_PI = 32'sd683565276;
	localparam logic signed [TAP_W-1:0]    HAM_A       = 32'sd579820585;
	localparam logic signed [TAP_W-1:0]    HAM_B       = 32'sd493921239;
	localparam logic signed [VAL_W-1:0]    COEF_MAX    = 56'sd8388607;
	localparam logic signed [VAL_W-1:0]    COEF_MIN    = -56'sd8388608;
	localparam logic signed [VAL_W-1:0]    ONE_Q20     = 56'sd1048576;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CUTOFF = 2'd1,
		ST_BAD_ORDER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIV_SINC,
		DIV_WANG,
		DIV_NORM
	} div_op_t;

	typedef enum logic [1:0] {
		MUL_SINC,
		MUL_WIN,
		MUL_TAP
	} mul_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_ERR,
		S_SINC_ANG,
		S_SINC_COR,
		S_SINC_MUL,
		S_SINC_DIV,
		S_WANG_GO,
		S_WANG_DIV,
		S_WIN_COR_GO,
		S_WIN_COR,
		S_WIN_MUL,
		S_TAP_MUL,
		S_TAP_FIN,
		S_NORM_RD,
		S_NORM_GO,
		S_NORM_DIV,
		S_NORM_OUT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    start_pass;
		logic    i_next;
		logic    i_zero;
		logic    cor_start;
		logic    cor_win;
		logic    div_start;
		div_op_t div_op;
		logic    mul_en;
		mul_op_t mul_op;
		logic    sinc_centre;
		logic    sinc_div;
		logic    wang_ld;
		logic    win_ld;
		logic    tap_ld;
		logic    rd;
		logic    out_ld;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic bad_cutoff;
		logic bad_order;
		logic d_zero;
		logic last;
		logic cor_done;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] k);
		logic [31:0] a;
		unique case (k)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2F9;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/windowed_sinc_fir_coefficients.sv
// ----------------------------------------------------------------------------
// windowed_sinc_fir_coefficients
// Designs a Hamming-windowed sinc fir filter from one command and streams
// its taps as signed Q3.20 values, normalised to unity gain at dc for low-pass.
//
// One command is taken at a time; the next is accepted once the previous
// one's last beat has been loaded into the output register. Each off-centre
// tap needs two 24-step cordic runs and two 53-step divides in the tap pass
// (the centre tap one of each), then one more 53-step divide in the
// normalising pass, all on one shared cordic unit and one shared bit-serial
// divider. A zero cutoff or an order outside 1..62 gives a single error beat.
// ----------------------------------------------------------------------------
module windowed_sinc_fir_coefficients (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // order[5:0], cutoff[21:6], zero pad
	input  logic        s_axis_tuser,   // high_pass
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // tap_index[5:0], coefficient[29:6], zero pad
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // status
);

	wsf_pkg::cmd_t               cmd;
	wsf_pkg::sts_t               sts;
	logic [wsf_pkg::IDX_W-1:0]   out_idx;
	logic [wsf_pkg::COEF_W-1:0]  out_coef;

	wsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wsf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.order      (s_axis_tdata[5:0]),
		.cutoff     (s_axis_tdata[21:6]),
		.high_pass  (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_idx    (out_idx),
		.out_coef   (out_coef),
		.out_last   (m_axis_tlast),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, out_coef, out_idx};

endmodule

FILE: rtl/wsf_ram.sv
// ----------------------------------------------------------------------------
// wsf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module wsf_ram #(
	parameter int W = 32,
	parameter int D = 63
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/wsf_cordic.sv
// ----------------------------------------------------------------------------
// wsf_cordic
// Iterative rotation cordic, one micro-rotation per cycle, giving sine and
// cosine in Q2.30 of an angle in 32-bit binary turns.
// ----------------------------------------------------------------------------
module wsf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);

	logic                                busy_q;
	logic                                done_q;
	logic [wsf_pkg::STEP_W-1:0]          k_q;
	logic signed [wsf_pkg::CORDIC_W-1:0] x_q, y_q, z_q;
	logic                                neg_q;
	logic signed [wsf_pkg::CORDIC_W-1:0] z0, xs, ys, at;
	logic signed [wsf_pkg::CORDIC_W-1:0] so, co;

	always_comb begin
		z0 = {{2{angle[31]}}, angle};
		xs = x_q >>> k_q;
		ys = y_q >>> k_q;
		at = {2'b00, wsf_pkg::atan_turns(k_q)};
		so = neg_q ? -y_q : y_q;
		co = neg_q ? -x_q : x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == wsf_pkg::STEP_W'(wsf_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= wsf_pkg::CORDIC_K;
			y_q <= '0;
			if (z0 > wsf_pkg::QUARTER) begin
				z_q   <= z0 - wsf_pkg::HALF;
				neg_q <= 1'b1;
			end else if (z0 < -wsf_pkg::QUARTER) begin
				z_q   <= z0 + wsf_pkg::HALF;
				neg_q <= 1'b1;
			end else begin
				z_q   <= z0;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[wsf_pkg::CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done   = done_q;
	assign sine   = so[31:0];
	assign cosine = co[31:0];

endmodule

FILE: rtl/wsf_div.sv
// ----------------------------------------------------------------------------
// wsf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wsf_pkg::DIV_NUM_W-1:0]  num,
	input  logic [wsf_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [wsf_pkg::DIV_NUM_W-1:0]  quo
);

	logic [wsf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [wsf_pkg::DIV_NUM_W-1:0] q_q;
	logic [wsf_pkg::DIV_DEN_W-1:0] r_q;
	logic [wsf_pkg::DIV_DEN_W-1:0] d_q;
	logic [wsf_pkg::DIV_DEN_W:0]   sh;
	logic [wsf_pkg::DIV_DEN_W:0]   diff;
	logic                          ge;

	always_comb begin
		sh   = {r_q, q_q[wsf_pkg::DIV_NUM_W-1]};
		ge   = sh >= {1'b0, d_q};
		diff = sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= wsf_pkg::DIV_CNT_W'(wsf_pkg::DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wsf_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != '0) begin
			q_q <= {q_q[wsf_pkg::DIV_NUM_W-2:0], ge};
			r_q <= ge ? diff[wsf_pkg::DIV_DEN_W-1:0] : sh[wsf_pkg::DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

FILE: rtl/wsf_ctrl.sv
// ----------------------------------------------------------------------------
// wsf_ctrl
// Sequencer: checks a command, runs the tap pass and the normalising pass.
// ----------------------------------------------------------------------------
module wsf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wsf_pkg::sts_t sts,
	output wsf_pkg::cmd_t cmd
);

	wsf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wsf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = wsf_pkg::S_CHECK;
				end
			end
			wsf_pkg::S_CHECK: begin
				if (sts.bad_cutoff || sts.bad_order) begin
					state_d = wsf_pkg::S_ERR;
				end else begin
					cmd.start_pass = 1'b1;
					state_d        = wsf_pkg::S_SINC_ANG;
				end
			end
			wsf_pkg::S_ERR: begin
				if (sts.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_status = sts.bad_cutoff ? wsf_pkg::ST_BAD_CUTOFF
					                                : wsf_pkg::ST_BAD_ORDER;
					state_d        = wsf_pkg::S_IDLE;
				end
			end
			wsf_pkg::S_SINC_ANG: begin
				if (sts.d_zero) begin
					cmd.sinc_centre = 1'b1;
					state_d         = wsf_pkg::S_WANG_GO;
				end else begin
					cmd.cor_start = 1'b1;
					state_d       = wsf_pkg::S_SINC_COR;
				end
			end
			wsf_pkg::S_SINC_COR: begin
				if (sts.cor_done) begin
					cmd.mul_en = 1'b1;
					cmd.mul_op = wsf_pkg::MUL_SINC;
					state_d    = wsf_pkg::S_SINC_MUL;
				end
			end
			wsf_pkg::S_SINC_MUL: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = wsf_pkg::DIV_SINC;
				state_d       = wsf_pkg::S_SINC_DIV;
			end
			wsf_pkg::S_SINC_DIV: begin
				if (sts.div_done) begin
					cmd.sinc_div = 1'b1;
					state_d      = wsf_pkg::S_WANG_GO;
				end
			end
			wsf_pkg::S_WANG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = wsf_pkg::DIV_WANG;
				state_d       = wsf_pkg::S_WANG_DIV;
			end
			wsf_pkg::S_WANG_DIV: begin
				if (sts.div_done) begin
					cmd.wang_ld = 1'b1;
					state_d     = wsf_pkg::S_WIN_COR_GO;
				end
			end
			wsf_pkg::S_WIN_COR_GO: begin
				cmd.cor_start = 1'b1;
				cmd.cor_win   = 1'b1;
				state_d       = wsf_pkg::S_WIN_COR;
			end
			wsf_pkg::S_WIN_COR: begin
				if (sts.cor_done) begin
					cmd.mul_en = 1'b1;
					cmd.mul_op = wsf_pkg::MUL_WIN;
					state_d    = wsf_pkg::S_WIN_MUL;
				end
			end
			wsf_pkg::S_WIN_MUL: begin
				cmd.win_ld = 1'b1;
				state_d    = wsf_pkg::S_TAP_MUL;
			end
			wsf_pkg::S_TAP_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wsf_pkg::MUL_TAP;
				state_d    = wsf_pkg::S_TAP_FIN;
			end
			wsf_pkg::S_TAP_FIN: begin
				cmd.tap_ld = 1'b1;
				if (sts.last) begin
					cmd.i_zero = 1'b1;
					state_d    = wsf_pkg::S_NORM_RD;
				end else begin
					cmd.i_next = 1'b1;
					state_d    = wsf_pkg::S_SINC_ANG;
				end
			end
			wsf_pkg::S_NORM_RD: begin
				cmd.rd  = 1'b1;
				state_d = wsf_pkg::S_NORM_GO;
			end
			wsf_pkg::S_NORM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = wsf_pkg::DIV_NORM;
				state_d       = wsf_pkg::S_NORM_DIV;
			end
			wsf_pkg::S_NORM_DIV: begin
				if (sts.div_done) begin
					state_d = wsf_pkg::S_NORM_OUT;
				end
			end
			wsf_pkg::S_NORM_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (sts.last) begin
						state_d = wsf_pkg::S_IDLE;
					end else begin
						cmd.i_next = 1'b1;
						state_d    = wsf_pkg::S_NORM_RD;
					end
				end
			end
			default: begin
				state_d = wsf_pkg::S_IDLE;
			end
		endcase
	end

	// a result beat is only loaded into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result loaded over an unsent beat");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == wsf_pkg::S_CHECK))
		else $error("accepted command not checked");

	a_tap_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_ld |-> $past(cmd.mul_en))
		else $error("tap stored without fresh product");

endmodule

FILE: rtl/wsf_dp.sv
// ----------------------------------------------------------------------------
// wsf_dp
// Datapath: command registers, tap counter, shared multiplier, cordic,
// divider, tap store, running sum and the output register.
// ----------------------------------------------------------------------------
module wsf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wsf_pkg::ORDER_W-1:0]  order,
	input  logic [wsf_pkg::CUTOFF_W-1:0] cutoff,
	input  logic                         high_pass,
	input  wsf_pkg::cmd_t                cmd,
	output wsf_pkg::sts_t                sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [wsf_pkg::IDX_W-1:0]    out_idx,
	output logic [wsf_pkg::COEF_W-1:0]   out_coef,
	output logic                         out_last,
	output logic [wsf_pkg::STATUS_W-1:0] out_status
);

	logic [wsf_pkg::ORDER_W-1:0]        order_q;
	logic [wsf_pkg::CUTOFF_W-1:0]       cutoff_q;
	logic                               hp_q;
	logic [wsf_pkg::ORDER_W-1:0]        i_q;
	logic signed [7:0]                  d;
	logic                               d_neg;
	logic [5:0]                         ad;
	logic [21:0]                        sinc_mag;
	logic [31:0]                        sinc_t, sinc_ang, cor_ang;
	logic signed [wsf_pkg::TAP_W-1:0]   mul_a, mul_b;
	logic signed [wsf_pkg::PROD_W-1:0]  prod_q, prod_rnd;
	logic [wsf_pkg::PROD_W-1:0]         prod_abs, sinc_sum;
	logic signed [wsf_pkg::TAP_W-1:0]   sinc_q, win_q, tap_val;
	logic [31:0]                        wang_q, q32;
	logic signed [wsf_pkg::SUM_W-1:0]   sum_q;
	logic [wsf_pkg::DIV_DEN_W-1:0]      divisor, div_den;
	logic [wsf_pkg::DIV_NUM_W-1:0]      div_num, quo;
	logic                               cor_done, div_done;
	logic signed [31:0]                 sine, cosine;
	logic [wsf_pkg::TAP_W-1:0]          ram_rd;
	logic [wsf_pkg::TAP_W-1:0]          tap_mag;
	logic signed [wsf_pkg::VAL_W-1:0]   vq, v;
	logic [wsf_pkg::COEF_W-1:0]         coef_sat;
	logic                               last;
	logic                               out_valid_q;
	logic [wsf_pkg::IDX_W-1:0]          idx_q;
	logic [wsf_pkg::COEF_W-1:0]         coef_q;
	logic                               last_q;
	logic [wsf_pkg::STATUS_W-1:0]       status_q;

	function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] q;
		m = p[63] ? 64'(-p) : 64'(p);
		q = (m + 64'd536870912) >> 30;
		return p[63] ? -signed'(q) : signed'(q);
	endfunction

	assign tap_mag = ram_rd[31] ? -ram_rd : ram_rd;

	always_comb begin
		d        = signed'({1'b0, i_q, 1'b0}) - signed'({2'b00, order_q});
		d_neg    = d[7];
		ad       = d_neg ? 6'(-d) : d[5:0];
		sinc_mag = 22'(cutoff_q) * 22'(ad);
		sinc_t   = {sinc_mag[17:0], 14'h0};
		sinc_ang = d_neg ? -sinc_t : sinc_t;
		cor_ang  = cmd.cor_win ? wang_q : sinc_ang;
		last     = i_q == order_q;

		case (cmd.mul_op)
			wsf_pkg::MUL_SINC: begin
				mul_a = sine;
				mul_b = wsf_pkg::TWO_OVER_PI;
			end
			wsf_pkg::MUL_WIN: begin
				mul_a = cosine;
				mul_b = wsf_pkg::HAM_B;
			end
			default: begin
				mul_a = sinc_q;
				mul_b = win_q;
			end
		endcase

		prod_abs = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
		prod_rnd = rnd30(prod_q);
		tap_val  = prod_rnd[31:0];
		sinc_sum = prod_abs + (64'(ad) << 29);
		q32      = quo[31:0];

		divisor  = (!sum_q[wsf_pkg::SUM_W-1] && sum_q != '0) ? 40'(sum_q) : 40'd1;

		case (cmd.div_op)
			wsf_pkg::DIV_SINC: begin
				div_num = wsf_pkg::DIV_NUM_W'(sinc_sum[63:30]);
				div_den = wsf_pkg::DIV_DEN_W'(ad);
			end
			wsf_pkg::DIV_WANG: begin
				div_num = wsf_pkg::DIV_NUM_W'({i_q, 32'h0})
				        + wsf_pkg::DIV_NUM_W'(order_q[5:1]);
				div_den = wsf_pkg::DIV_DEN_W'(order_q);
			end
			default: begin
				div_num = wsf_pkg::DIV_NUM_W'({tap_mag, 20'h0})
				        + wsf_pkg::DIV_NUM_W'(divisor[wsf_pkg::DIV_DEN_W-1:1]);
				div_den = divisor;
			end
		endcase

		vq = wsf_pkg::VAL_W'(quo);
		v  = ram_rd[31] ? -vq : vq;
		if (hp_q) begin
			v = -v;
			if (i_q == {1'b0, order_q[5:1]}) begin
				v = v + wsf_pkg::ONE_Q20;
			end
		end
		if (v > wsf_pkg::COEF_MAX) begin
			coef_sat = wsf_pkg::COEF_MAX[wsf_pkg::COEF_W-1:0];
		end else if (v < wsf_pkg::COEF_MIN) begin
			coef_sat = wsf_pkg::COEF_MIN[wsf_pkg::COEF_W-1:0];
		end else begin
			coef_sat = v[wsf_pkg::COEF_W-1:0];
		end
	end

	wsf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_start),
		.angle  (cor_ang),
		.done   (cor_done),
		.sine   (sine),
		.cosine (cosine)
	);

	wsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	wsf_ram #(
		.W (wsf_pkg::TAP_W),
		.D (wsf_pkg::TAP_DEPTH)
	) u_tap_store (
		.clk   (clk),
		.we    (cmd.tap_ld),
		.waddr (i_q),
		.wdata (tap_val),
		.re    (cmd.rd),
		.raddr (i_q),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_pass || cmd.i_zero) begin
				i_q <= '0;
			end else if (cmd.i_next) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.start_pass) begin
				sum_q <= '0;
			end else if (cmd.tap_ld) begin
				sum_q <= sum_q + {{8{tap_val[31]}}, tap_val};
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			order_q  <= order;
			cutoff_q <= cutoff;
			hp_q     <= high_pass;
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (cmd.sinc_centre) begin
			sinc_q <= 32'({cutoff_q, 14'h0});
		end else if (cmd.sinc_div) begin
			sinc_q <= (prod_q[63] ^ d_neg) ? -q32 : q32;
		end
		if (cmd.wang_ld) begin
			wang_q <= q32;
		end
		if (cmd.win_ld) begin
			win_q <= wsf_pkg::HAM_A - tap_val;
		end
		if (cmd.out_ld) begin
			if (cmd.out_status != wsf_pkg::ST_OK) begin
				idx_q  <= '0;
				coef_q <= '0;
				last_q <= 1'b1;
			end else begin
				idx_q  <= i_q;
				coef_q <= coef_sat;
				last_q <= last;
			end
			status_q <= cmd.out_status;
		end
	end

	always_comb begin
		sts.bad_cutoff = cutoff_q == '0;
		sts.bad_order  = order_q == '0
		              || order_q > wsf_pkg::ORDER_W'(wsf_pkg::MAX_ORDER);
		sts.d_zero     = d == '0;
		sts.last       = last;
		sts.cor_done   = cor_done;
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_idx    = idx_q;
	assign out_coef   = coef_q;
	assign out_last   = last_q;
	assign out_status = status_q;

endmodule
